/* design/pps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and tables shared by the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_WAYPOINTS = 256;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_KW     = $clog2(CORDIC_STEPS);
  localparam int SQ_STEPS      = 33;
  localparam int SQ_KW         = $clog2(SQ_STEPS);

  localparam int PI_Q24       = 52707179;
  localparam int HALF_PI_Q24  = 26353589;
  localparam int TWO_PI_Q24   = 105414357;
  localparam int CORDIC_K_Q24 = 10188014;
  localparam int ONE_Q24      = 16777216;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_LOOKAHEAD = 3'd0;
  localparam logic [2:0] REG_SPEED     = 3'd1;
  localparam logic [2:0] REG_GAIN      = 3'd2;
  localparam logic [2:0] REG_TOLERANCE = 3'd3;
  localparam logic [2:0] REG_RATE_LIM  = 3'd4;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_POSE   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_GOAL  = 2'd2,
    STAT_DROP  = 2'd3
  } stat_t;

  typedef struct packed {
    logic [30:0] lookahead;
    logic [14:0] speed;
    logic [15:0] gain;
    logic [30:0] tolerance;
    logic [14:0] rate_lim;
  } cfg_t;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_APPEND,
    OP_RES_EMPTY,
    OP_RES_GOAL,
    OP_RES_NONE,
    OP_RD_LAST,
    OP_RD_I,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_D3,
    OP_TOL,
    OP_NEAR_INIT,
    OP_NEAR_UPD,
    OP_WALK_INIT,
    OP_PREV,
    OP_END,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_ARC,
    OP_HIT,
    OP_ADV,
    OP_AT_INIT,
    OP_AT_STEP,
    OP_ALPHA,
    OP_E13,
    OP_GMUL,
    OP_ANG,
    OP_COS_INIT,
    OP_COS_STEP,
    OP_CS,
    OP_LMUL,
    OP_LIN,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       count_zero;
    logic       goal_hit;
    logic       i_end;
    logic       sq_done;
    logic       arc_hit;
    logic       vec_zero;
    logic       k_last;
    logic       cos_zero;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_TOL,
    ST_GOAL_CMP,
    ST_NEAR_RD,
    ST_NEAR_UPD,
    ST_NEAR_CHK,
    ST_WALK_INIT,
    ST_WALK_PREV,
    ST_WALK_CHK,
    ST_SQ_INIT,
    ST_SQ_RUN,
    ST_ARC,
    ST_ARC_TEST,
    ST_AT_INIT,
    ST_AT_CHK,
    ST_AT_RUN,
    ST_ALPHA,
    ST_E13,
    ST_GMUL,
    ST_ANG,
    ST_COS_INIT,
    ST_COS_CHK,
    ST_COS_RUN,
    ST_CS,
    ST_LMUL,
    ST_LIN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_GOAL,
    PH_NEAR,
    PH_WALK
  } phase_t;

  function automatic logic [24:0] atan_q24(input logic [4:0] k);
    logic [24:0] v;
    unique case (k)
      5'd0:    v = 25'd13176795;
      5'd1:    v = 25'd7778716;
      5'd2:    v = 25'd4110060;
      5'd3:    v = 25'd2086331;
      5'd4:    v = 25'd1047214;
      5'd5:    v = 25'd524117;
      5'd6:    v = 25'd262123;
      5'd7:    v = 25'd131069;
      5'd8:    v = 25'd65536;
      5'd9:    v = 25'd32768;
      5'd10:   v = 25'd16384;
      5'd11:   v = 25'd8192;
      5'd12:   v = 25'd4096;
      5'd13:   v = 25'd2048;
      5'd14:   v = 25'd1024;
      5'd15:   v = 25'd512;
      5'd16:   v = 25'd256;
      5'd17:   v = 25'd128;
      5'd18:   v = 25'd64;
      5'd19:   v = 25'd32;
      5'd20:   v = 25'd16;
      5'd21:   v = 25'd8;
      5'd22:   v = 25'd4;
      5'd23:   v = 25'd2;
      5'd24:   v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/pps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pps_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cfg
// APB register file holding the tracking configuration.
// ----------------------------------------------------------------------------
module pps_cfg
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead <= 31'd32768;
      cfg.speed     <= 15'd614;
      cfg.gain      <= 16'd384;
      cfg.tolerance <= 31'd16384;
      cfg.rate_lim  <= 15'd4096;
    end else if (wr) begin
      unique case (idx)
        REG_LOOKAHEAD: cfg.lookahead <= pwdata[30:0];
        REG_SPEED:     cfg.speed     <= pwdata[14:0];
        REG_GAIN:      cfg.gain      <= pwdata[15:0];
        REG_TOLERANCE: cfg.tolerance <= pwdata[30:0];
        REG_RATE_LIM:  cfg.rate_lim  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOOKAHEAD: prdata = {1'b0, cfg.lookahead};
      REG_SPEED:     prdata = {17'd0, cfg.speed};
      REG_GAIN:      prdata = {16'd0, cfg.gain};
      REG_TOLERANCE: prdata = {1'b0, cfg.tolerance};
      REG_RATE_LIM:  prdata = {17'd0, cfg.rate_lim};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* design/pps_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_datapath
// Path store, shared multiplier, square root, CORDIC and result registers.
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  cfg_t               cfg,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] waypoint_x,
  input  logic signed [31:0] waypoint_y,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_heading,
  output logic [1:0]         status,
  output logic [14:0]        linear_command,
  output logic signed [15:0] angular_command,
  output logic [7:0]         target_index,
  output logic signed [15:0] heading_error
);

  localparam logic signed [29:0] PI_A     = 30'(PI_Q24);
  localparam logic signed [29:0] TWO_PI_A = 30'(TWO_PI_Q24);

  logic [1:0]         req;
  logic signed [31:0] wx, wy, rx, ry;
  logic signed [15:0] yaw;
  logic [CNT_W-1:0]   count, i;
  logic [IDX_W-1:0]   near, la;
  logic signed [31:0] qx, qy, px, py;
  logic               walk;
  logic [31:0]        dxm, dym;
  logic [63:0]        p1, p2;
  logic [64:0]        sum, best;
  logic [65:0]        sqv;
  logic [32:0]        root;
  logic [35:0]        rem;
  logic [SQ_KW-1:0]   sqk;
  logic [33:0]        arc;
  logic signed [35:0] cor_x, cor_y;
  logic signed [27:0] cor_z;
  logic [CORDIC_KW-1:0] cor_k;
  logic signed [29:0] alpha;
  logic signed [15:0] e13;
  logic [24:0]        cs;
  stat_t              res_status;
  logic [14:0]        res_lin;
  logic signed [15:0] res_ang;
  logic [7:0]         res_tidx;
  logic signed [15:0] res_herr;

  logic               full;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic signed [31:0] ram_x, ram_y;
  logic signed [31:0] ox, oy;
  logic signed [32:0] dx_s, dy_s;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [35:0]        sq_r2, sq_t;
  logic signed [35:0] xs, ys;
  logic signed [27:0] at;
  logic signed [32:0] vx, vy;
  logic signed [29:0] a0, a1, a2;
  logic [29:0]        amag;
  logic [29:0]        around;
  logic [15:0]        emag;
  logic [32:0]        ang_t;
  logic [23:0]        ang_m;
  logic [14:0]        ang_c;
  logic [40:0]        lin_t;
  logic [16:0]        lin_l;

  assign full  = (count == CNT_W'(MAX_WAYPOINTS));
  assign we    = (cmd.op == OP_APPEND) && !full;

  always_comb begin
    unique case (cmd.op)
      OP_RD_LAST:   raddr = IDX_W'(count - 1'b1);
      OP_WALK_INIT: raddr = near;
      default:      raddr = i[IDX_W-1:0];
    endcase
  end

  pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
    .clk(clk), .we(we), .waddr(count[IDX_W-1:0]), .wdata(wx),
    .raddr(raddr), .rdata(ram_x)
  );

  pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
    .clk(clk), .we(we), .waddr(count[IDX_W-1:0]), .wdata(wy),
    .raddr(raddr), .rdata(ram_y)
  );

  assign ox   = walk ? px : rx;
  assign oy   = walk ? py : ry;
  assign dx_s = {ram_x[31], ram_x} - {ox[31], ox};
  assign dy_s = {ram_y[31], ram_y} - {oy[31], oy};

  always_comb begin
    unique case (cmd.op)
      OP_D1:   begin mul_a = dxm;               mul_b = dxm;              end
      OP_D2:   begin mul_a = dym;               mul_b = dym;              end
      OP_TOL:  begin mul_a = {1'b0, cfg.tolerance}; mul_b = {1'b0, cfg.tolerance}; end
      OP_GMUL: begin mul_a = {16'd0, cfg.gain}; mul_b = {16'd0, emag};    end
      default: begin mul_a = {17'd0, cfg.speed}; mul_b = {7'd0, cs};      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sq_r2 = {rem[33:0], sqv[65:64]};
  assign sq_t  = {1'b0, root, 2'b01};

  assign xs = cor_x >>> cor_k;
  assign ys = cor_y >>> cor_k;
  assign at = {3'd0, atan_q24(5'(cor_k))};

  assign vx = {px[31], px} - {rx[31], rx};
  assign vy = {py[31], py} - {ry[31], ry};

  assign a0 = {{2{cor_z[27]}}, cor_z} - {{3{yaw[15]}}, yaw, 11'd0};
  assign a1 = (a0 > PI_A) ? a0 - TWO_PI_A : a0;
  assign a2 = (a1 < -PI_A) ? a1 + TWO_PI_A : a1;

  assign amag   = alpha[29] ? 30'(-alpha) : alpha;
  assign around = (amag + 30'd1024) >> 11;
  assign emag   = e13[15] ? 16'(-e13) : e13;

  assign ang_t = p1[32:0] + 33'd256;
  assign ang_m = ang_t[32:9];
  assign ang_c = (ang_m > {9'd0, cfg.rate_lim}) ? cfg.rate_lim : ang_m[14:0];

  assign lin_t = {1'b0, p1[39:0]} + 41'(ONE_Q24 / 2);
  assign lin_l = lin_t[40:24];

  assign sts.req        = req;
  assign sts.count_zero = (count == '0);
  assign sts.goal_hit   = (sum < {1'b0, p1});
  assign sts.i_end      = (i == count);
  assign sts.sq_done    = (sqk == SQ_KW'(SQ_STEPS - 1));
  assign sts.arc_hit    = (arc >= {3'd0, cfg.lookahead});
  assign sts.vec_zero   = (cor_x == '0) && (cor_y == '0);
  assign sts.k_last     = (cor_k == CORDIC_KW'(CORDIC_STEPS - 1));
  assign sts.cos_zero   = ({emag, 11'd0} >= 27'(HALF_PI_Q24));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR:  count <= '0;
        OP_APPEND: if (!full) count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req <= req_type;
        wx  <= waypoint_x;
        wy  <= waypoint_y;
        rx  <= robot_x;
        ry  <= robot_y;
        yaw <= robot_heading;
      end
      OP_CLEAR, OP_RES_NONE: begin
        res_status <= STAT_OK;
        res_lin <= '0; res_ang <= '0; res_tidx <= '0; res_herr <= '0;
      end
      OP_APPEND: begin
        res_status <= full ? STAT_DROP : STAT_OK;
        res_lin <= '0; res_ang <= '0; res_tidx <= '0; res_herr <= '0;
      end
      OP_RES_EMPTY: begin
        res_status <= STAT_EMPTY;
        res_lin <= '0; res_ang <= '0; res_tidx <= '0; res_herr <= '0;
      end
      OP_RES_GOAL: begin
        res_status <= STAT_GOAL;
        res_lin <= '0; res_ang <= '0; res_tidx <= '0; res_herr <= '0;
      end
      OP_RD_LAST: walk <= 1'b0;
      OP_D0: begin
        qx  <= ram_x;
        qy  <= ram_y;
        dxm <= dx_s[32] ? 32'(-dx_s) : dx_s[31:0];
        dym <= dy_s[32] ? 32'(-dy_s) : dy_s[31:0];
      end
      OP_D1, OP_TOL, OP_GMUL, OP_LMUL: p1 <= mul_p;
      OP_D2: p2 <= mul_p;
      OP_D3: sum <= {1'b0, p1} + {1'b0, p2};
      OP_NEAR_INIT: begin
        i    <= '0;
        walk <= 1'b0;
      end
      OP_NEAR_UPD: begin
        if ((i == '0) || (sum < best)) begin
          best <= sum;
          near <= i[IDX_W-1:0];
        end
        i <= i + 1'b1;
      end
      OP_WALK_INIT: begin
        walk <= 1'b1;
        arc  <= '0;
        i    <= {1'b0, near} + 1'b1;
      end
      OP_PREV: begin
        px <= ram_x;
        py <= ram_y;
      end
      OP_END: la <= IDX_W'(count - 1'b1);
      OP_SQ_INIT: begin
        sqv  <= {1'b0, sum};
        root <= '0;
        rem  <= '0;
        sqk  <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_r2 >= sq_t) begin
          rem  <= sq_r2 - sq_t;
          root <= {root[31:0], 1'b1};
        end else begin
          rem  <= sq_r2;
          root <= {root[31:0], 1'b0};
        end
        sqv <= {sqv[63:0], 2'b00};
        sqk <= sqk + 1'b1;
      end
      OP_ARC: arc <= arc + {1'b0, root};
      OP_HIT: begin
        la <= i[IDX_W-1:0];
        px <= qx;
        py <= qy;
      end
      OP_ADV: begin
        px <= qx;
        py <= qy;
        i  <= i + 1'b1;
      end
      OP_AT_INIT: begin
        cor_k <= '0;
        if (vx[32]) begin
          if (!vy[32]) begin
            cor_x <= 36'(vy);
            cor_y <= -36'(vx);
            cor_z <= 28'(HALF_PI_Q24);
          end else begin
            cor_x <= -36'(vy);
            cor_y <= 36'(vx);
            cor_z <= -28'(HALF_PI_Q24);
          end
        end else begin
          cor_x <= 36'(vx);
          cor_y <= 36'(vy);
          cor_z <= '0;
        end
      end
      OP_AT_STEP: begin
        cor_k <= cor_k + 1'b1;
        if (!cor_y[35] && (cor_y != '0)) begin
          cor_x <= cor_x + ys;
          cor_y <= cor_y - xs;
          cor_z <= cor_z + at;
        end else begin
          cor_x <= cor_x - ys;
          cor_y <= cor_y + xs;
          cor_z <= cor_z - at;
        end
      end
      OP_ALPHA: alpha <= a2;
      OP_E13:   e13 <= alpha[29] ? -16'(around) : 16'(around);
      OP_ANG:   res_ang <= e13[15] ? -{1'b0, ang_c} : {1'b0, ang_c};
      OP_COS_INIT: begin
        cor_k <= '0;
        cor_x <= 36'(CORDIC_K_Q24);
        cor_y <= '0;
        cor_z <= {e13[15], e13, 11'd0};
      end
      OP_COS_STEP: begin
        cor_k <= cor_k + 1'b1;
        if (!cor_z[27]) begin
          cor_x <= cor_x - ys;
          cor_y <= cor_y + xs;
          cor_z <= cor_z - at;
        end else begin
          cor_x <= cor_x + ys;
          cor_y <= cor_y - xs;
          cor_z <= cor_z + at;
        end
      end
      OP_CS: begin
        if (sts.cos_zero || cor_x[35]) begin
          cs <= '0;
        end else if (cor_x[34:0] > 35'(ONE_Q24)) begin
          cs <= 25'(ONE_Q24);
        end else begin
          cs <= cor_x[24:0];
        end
      end
      OP_LIN: begin
        res_lin    <= (lin_l > 17'd32767) ? 15'h7FFF : lin_l[14:0];
        res_status <= STAT_OK;
        res_tidx   <= 8'(la);
        res_herr   <= e13;
      end
      OP_PUSH: begin
        status          <= res_status;
        linear_command  <= res_lin;
        angular_command <= res_ang;
        target_index    <= res_tidx;
        heading_error   <= res_herr;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WAYPOINTS))
    else $error("path count beyond store depth");

  a_near_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_WALK_INIT) |-> ({1'b0, near} < count))
    else $error("nearest waypoint outside path");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LIN) |-> (cs <= 25'(ONE_Q24)))
    else $error("cosine above unity");
`endif

endmodule

/* design/pps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for requests: path loads, goal test, nearest search, lookahead
// walk, heading and command computation, and the output register valid.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_GOAL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.op == OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.req == REQ_POSE && !sts.count_zero) begin
          state_next = ST_D0;
          phase_next = PH_GOAL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_D0: state_next = ST_D1;
      ST_D1: state_next = ST_D2;
      ST_D2: state_next = ST_D3;
      ST_D3: begin
        unique case (phase)
          PH_GOAL: state_next = ST_TOL;
          PH_NEAR: state_next = ST_NEAR_UPD;
          default: state_next = ST_SQ_INIT;
        endcase
      end
      ST_TOL:      state_next = ST_GOAL_CMP;
      ST_GOAL_CMP: state_next = sts.goal_hit ? ST_FINISH : ST_NEAR_RD;
      ST_NEAR_RD: begin
        state_next = ST_D0;
        phase_next = PH_NEAR;
      end
      ST_NEAR_UPD:  state_next = ST_NEAR_CHK;
      ST_NEAR_CHK:  state_next = sts.i_end ? ST_WALK_INIT : ST_NEAR_RD;
      ST_WALK_INIT: state_next = ST_WALK_PREV;
      ST_WALK_PREV: state_next = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (sts.i_end) begin
          state_next = ST_AT_INIT;
        end else begin
          state_next = ST_D0;
          phase_next = PH_WALK;
        end
      end
      ST_SQ_INIT:  state_next = ST_SQ_RUN;
      ST_SQ_RUN:   if (sts.sq_done) state_next = ST_ARC;
      ST_ARC:      state_next = ST_ARC_TEST;
      ST_ARC_TEST: state_next = sts.arc_hit ? ST_AT_INIT : ST_WALK_CHK;
      ST_AT_INIT:  state_next = ST_AT_CHK;
      ST_AT_CHK:   state_next = sts.vec_zero ? ST_ALPHA : ST_AT_RUN;
      ST_AT_RUN:   if (sts.k_last) state_next = ST_ALPHA;
      ST_ALPHA:    state_next = ST_E13;
      ST_E13:      state_next = ST_GMUL;
      ST_GMUL:     state_next = ST_ANG;
      ST_ANG:      state_next = ST_COS_INIT;
      ST_COS_INIT: state_next = ST_COS_CHK;
      ST_COS_CHK:  state_next = sts.cos_zero ? ST_CS : ST_COS_RUN;
      ST_COS_RUN:  if (sts.k_last) state_next = ST_CS;
      ST_CS:       state_next = ST_LMUL;
      ST_LMUL:     state_next = ST_LIN;
      ST_LIN:      state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE: if (in_valid) cmd.op = OP_LOAD;
      ST_DISPATCH: begin
        unique case (sts.req)
          REQ_CLEAR:  cmd.op = OP_CLEAR;
          REQ_APPEND: cmd.op = OP_APPEND;
          REQ_POSE:   cmd.op = sts.count_zero ? OP_RES_EMPTY : OP_RD_LAST;
          default:    cmd.op = OP_RES_NONE;
        endcase
      end
      ST_D0:        cmd.op = OP_D0;
      ST_D1:        cmd.op = OP_D1;
      ST_D2:        cmd.op = OP_D2;
      ST_D3:        cmd.op = OP_D3;
      ST_TOL:       cmd.op = OP_TOL;
      ST_GOAL_CMP:  cmd.op = sts.goal_hit ? OP_RES_GOAL : OP_NEAR_INIT;
      ST_NEAR_RD:   cmd.op = OP_RD_I;
      ST_NEAR_UPD:  cmd.op = OP_NEAR_UPD;
      ST_WALK_INIT: cmd.op = OP_WALK_INIT;
      ST_WALK_PREV: cmd.op = OP_PREV;
      ST_WALK_CHK:  cmd.op = sts.i_end ? OP_END : OP_RD_I;
      ST_SQ_INIT:   cmd.op = OP_SQ_INIT;
      ST_SQ_RUN:    cmd.op = OP_SQ_STEP;
      ST_ARC:       cmd.op = OP_ARC;
      ST_ARC_TEST:  cmd.op = sts.arc_hit ? OP_HIT : OP_ADV;
      ST_AT_INIT:   cmd.op = OP_AT_INIT;
      ST_AT_RUN:    cmd.op = OP_AT_STEP;
      ST_ALPHA:     cmd.op = OP_ALPHA;
      ST_E13:       cmd.op = OP_E13;
      ST_GMUL:      cmd.op = OP_GMUL;
      ST_ANG:       cmd.op = OP_ANG;
      ST_COS_INIT:  cmd.op = OP_COS_INIT;
      ST_COS_RUN:   cmd.op = OP_COS_STEP;
      ST_CS:        cmd.op = OP_CS;
      ST_LMUL:      cmd.op = OP_LMUL;
      ST_LIN:       cmd.op = OP_LIN;
      ST_FINISH:    if (out_free) cmd.op = OP_PUSH;
      default:      cmd.op = OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_DISPATCH))
    else $error("accepted request did not start");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUSH) |-> (!out_valid || !out_stall))
    else $error("result pushed over a pending result");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUSH) |=> (out_valid && state == ST_IDLE))
    else $error("pushed result not presented");
`endif

endmodule

/* design/pure_pursuit_steering_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// Pure pursuit path tracker: waypoint store and steering command generator.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// in        in_valid / in_stall       req_type, waypoint_x/y, robot_x/y, robot_heading
// out       out_valid / out_stall     status, linear_command, angular_command,
//                                     target_index, heading_error
// config    APB psel/penable/pready   paddr, pwdata, prdata
//
// Clear, append, unused and empty-path requests finish straight after dispatch, a goal
// hit after the goal test. A tracking pose request runs the goal test, the nearest
// search over n points, the lookahead walk with 33 square root steps per walked
// segment, and up to 2*16 CORDIC steps.
// Synchronous reset empties the path and loads register defaults.
// A new request is taken while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_top
  import pps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] waypoint_x,
  input  logic signed [31:0] waypoint_y,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [14:0]        linear_command,
  output logic signed [15:0] angular_command,
  output logic [7:0]         target_index,
  output logic signed [15:0] heading_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  pps_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  pps_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cfg(cfg),
    .req_type(req_type), .waypoint_x(waypoint_x), .waypoint_y(waypoint_y),
    .robot_x(robot_x), .robot_y(robot_y), .robot_heading(robot_heading),
    .status(status), .linear_command(linear_command),
    .angular_command(angular_command), .target_index(target_index),
    .heading_error(heading_error)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pure pursuit steering block. Requests are
// predicted by an in-bench fixed point tracker and every response is compared
// field by field, under random sender gaps, receiver stalls and register
// settings.
// ----------------------------------------------------------------------------
module tb_top;
  import pps_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint ANG_PI = 52707179;
  localparam longint ANG_HALF_PI = 26353589;
  localparam longint ANG_TWO_PI = 105414357;
  localparam longint GAIN_K = 10188014;
  localparam longint UNIT = 16777216;
  localparam longint ARC_TAN [16] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  typedef struct {
    logic [1:0]         status;
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic [7:0]         tidx;
    logic signed [15:0] herr;
  } steer_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic signed [31:0] waypoint_x, waypoint_y, robot_x, robot_y;
  logic signed [15:0] robot_heading;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [14:0] linear_command;
  logic signed [15:0] angular_command;
  logic [7:0] target_index;
  logic signed [15:0] heading_error;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  pure_pursuit_steering_top dut (.*);

  logic signed [31:0] path_x [MAX_WAYPOINTS];
  logic signed [31:0] path_y [MAX_WAYPOINTS];
  int path_len;
  logic [30:0] la_dist, tol_dist;
  logic [14:0] speed, rate_lim;
  logic [15:0] gain;

  steer_t pending_q [$];
  int mismatches, checked, sent, poses, burst_left, hold_left;
  longint cycles;
  bit no_gaps;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [64:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] bx, logic signed [31:0] by);
    longint dx, dy;
    logic [63:0] mx, my;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    return {1'b0, mx * mx} + {1'b0, my * my};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [64:0] v);
    logic [65:0] vv;
    logic [67:0] rem, t;
    logic [63:0] root;
    vv = {1'b0, v};
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | vv[2*i+1 -: 2];
      t = {root, 2'b01};
      if (rem >= t) begin
        rem = rem - t;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic longint bearing(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -ANG_HALF_PI;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ARC_TAN[i];
      end else begin
        x -= ys; y += xs; z -= ARC_TAN[i];
      end
    end
    return z;
  endfunction

  function automatic longint cosine(longint z);
    longint x, y, xs, ys;
    x = GAIN_K;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARC_TAN[i];
      end else begin
        x += ys; y -= xs; z += ARC_TAN[i];
      end
    end
    return x;
  endfunction

  function automatic longint round_shr(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic steer_t track(logic [1:0] req, logic signed [31:0] wx,
                                   logic signed [31:0] wy, logic signed [31:0] rx,
                                   logic signed [31:0] ry, logic signed [15:0] yaw);
    steer_t r;
    logic [64:0] d, best;
    logic [63:0] arc;
    longint alpha, e13, a, cs, lin;
    int nearest, target;
    r = '{default: 0};
    if (req == REQ_CLEAR) begin
      path_len = 0;
    end else if (req == REQ_APPEND) begin
      if (path_len < MAX_WAYPOINTS) begin
        path_x[path_len] = wx;
        path_y[path_len] = wy;
        path_len++;
      end else begin
        r.status = STAT_DROP;
      end
    end else if (req == REQ_POSE) begin
      if (path_len == 0) begin
        r.status = STAT_EMPTY;
      end else if (sq_dist(rx, ry, path_x[path_len-1], path_y[path_len-1]) <
                   {1'b0, 64'(tol_dist) * 64'(tol_dist)}) begin
        r.status = STAT_GOAL;
      end else begin
        nearest = 0;
        best = sq_dist(rx, ry, path_x[0], path_y[0]);
        for (int i = 1; i < path_len; i++) begin
          d = sq_dist(rx, ry, path_x[i], path_y[i]);
          if (d < best) begin
            best = d;
            nearest = i;
          end
        end
        target = path_len - 1;
        arc = 0;
        for (int i = nearest + 1; i < path_len; i++) begin
          arc += int_sqrt(sq_dist(path_x[i], path_y[i], path_x[i-1], path_y[i-1]));
          if (arc >= 64'(la_dist)) begin
            target = i;
            break;
          end
        end
        alpha = bearing(longint'(path_y[target]) - ry, longint'(path_x[target]) - rx)
                - longint'(yaw) * 2048;
        if (alpha > ANG_PI) alpha -= ANG_TWO_PI;
        if (alpha < -ANG_PI) alpha += ANG_TWO_PI;
        e13 = round_shr(alpha, 11);
        a = round_shr(longint'(gain) * e13, 9);
        if (a > longint'(rate_lim)) a = rate_lim;
        if (a < -longint'(rate_lim)) a = -longint'(rate_lim);
        alpha = e13 * 2048;
        if (alpha >= ANG_HALF_PI || alpha <= -ANG_HALF_PI) begin
          cs = 0;
        end else begin
          cs = cosine(alpha);
          if (cs < 0) cs = 0;
          if (cs > UNIT) cs = UNIT;
        end
        lin = (longint'(speed) * cs + (longint'(1) << 23)) >>> 24;
        if (lin > 32767) lin = 32767;
        r.lin = lin[14:0];
        r.ang = a[15:0];
        r.herr = e13[15:0];
        r.tidx = target[7:0];
      end
    end
    return r;
  endfunction

  int stall_pct;
  initial begin
    stall_pct = 0;
  end

  always @(posedge clk) begin
    steer_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (cycles % 97 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
        end else begin
          e = pending_q.pop_front();
          if (e.status !== status || e.lin !== linear_command || e.ang !== angular_command
              || e.tidx !== target_index || e.herr !== heading_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       e.status, e.lin, e.ang, e.tidx, e.herr, status, linear_command,
                       angular_command, target_index, heading_error);
          end
        end
      end
    end
  end

  task automatic send_req(logic [1:0] req, logic signed [31:0] wx, logic signed [31:0] wy,
                          logic signed [31:0] rx, logic signed [31:0] ry,
                          logic signed [15:0] yaw);
    if (burst_left <= 0 && !no_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    req_type <= req;
    waypoint_x <= wx;
    waypoint_y <= wy;
    robot_x <= rx;
    robot_y <= ry;
    robot_heading <= yaw;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(track(req, wx, wy, rx, ry, yaw));
    sent++;
    if (req == REQ_POSE) poses++;
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOOKAHEAD: la_dist = val[30:0];
      REG_SPEED: speed = val[14:0];
      REG_GAIN: gain = val[15:0];
      REG_TOLERANCE: tol_dist = val[30:0];
      REG_RATE_LIM: rate_lim = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] l, logic [31:0] s, logic [31:0] g,
                         logic [31:0] t, logic [31:0] r);
    write_reg(REG_LOOKAHEAD, l);
    write_reg(REG_SPEED, s);
    write_reg(REG_GAIN, g);
    write_reg(REG_TOLERANCE, t);
    write_reg(REG_RATE_LIM, r);
  endtask

  function automatic logic signed [31:0] any_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic logic signed [15:0] any_yaw();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 51472))) - 16'sd25736;
  endfunction

  task automatic test_directed();
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
    send_req(REQ_POSE, 0, 0, 100, 100, 0);
    send_req(REQ_APPEND, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, 65536, 0, 0, 0, 0);
    send_req(REQ_APPEND, 65536, 65536, 0, 0, 0);
    send_req(REQ_POSE, 0, 0, 65536, 65536, 0);
    send_req(REQ_POSE, 0, 0, -20000, 3000, 16'sd25736);
    send_req(REQ_POSE, 0, 0, -20000, 3000, -16'sd25736);
    send_req(REQ_POSE, 0, 0, 5000, -9000, 16'sh8000);
    send_req(REQ_POSE, 0, 0, 5000, -9000, 16'sh7fff);
    send_req(REQ_UNUSED, -1, -1, -1, -1, -1);
    send_req(REQ_APPEND, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
    send_req(REQ_APPEND, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
    send_req(REQ_POSE, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
    send_req(REQ_POSE, 0, 0, 32'sh80000000, 32'sh80000000, 0);
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, 200000, 0, 0, 0, 0);
    send_req(REQ_APPEND, -200000, 0, 0, 0, 0);
    send_req(REQ_APPEND, 0, 900000, 0, 0, 0);
    send_req(REQ_POSE, 0, 0, 0, -50000, 0);
    send_req(REQ_POSE, 0, 0, -300000, 10, 0);
    drain();
  endtask

  task automatic test_full_store();
    set_all(32'h7fffffff, 4096, 256, 0, 32767);
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i <= MAX_WAYPOINTS; i++)
      send_req(REQ_APPEND, any_coord(), any_coord(), 0, 0, 0);
    send_req(REQ_POSE, 0, 0, path_x[0], path_y[0], any_yaw());
    send_req(REQ_POSE, 0, 0, any_coord(), any_coord(), any_yaw());
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_backpressure();
    send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
    send_req(REQ_APPEND, 10000, 10000, 0, 0, 0);
    drain();
    hold_left = 3000;
    no_gaps = 1;
    for (int i = 0; i < 24; i++)
      send_req(i % 2 ? REQ_POSE : REQ_APPEND, any_coord(), any_coord(), any_coord(),
               any_coord(), any_yaw());
    no_gaps = 0;
    drain();
  endtask

  task automatic test_random(int quota);
    int pts;
    logic signed [31:0] bx, by;
    while (quota > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(2'($urandom), $urandom, $urandom, $urandom, $urandom, 16'($urandom));
        quota--;
        continue;
      end
      send_req(REQ_CLEAR, 0, 0, 0, 0, 0);
      bx = any_coord();
      by = any_coord();
      pts = $urandom_range(1, 10);
      for (int i = 0; i < pts; i++) begin
        bx += $signed($urandom_range(0, 131072)) - 32768;
        by += $signed($urandom_range(0, 131072)) - 32768;
        send_req(REQ_APPEND, ($urandom_range(0, 5) == 0) ? path_x[0] : bx, by, 0, 0, 0);
      end
      quota -= pts + 1;
      for (int i = $urandom_range(2, 6); i > 0; i--) begin
        if ($urandom_range(0, 5) == 0)
          send_req(REQ_POSE, 0, 0, path_x[path_len-1] + $signed($urandom_range(0, 60)) - 30,
                   path_y[path_len-1], any_yaw());
        else
          send_req(REQ_POSE, 0, 0, bx + $signed($urandom_range(0, 400000)) - 200000,
                   by + $signed($urandom_range(0, 400000)) - 200000, any_yaw());
        quota--;
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 0; req_type = 0; waypoint_x = 0; waypoint_y = 0;
    robot_x = 0; robot_y = 0; robot_heading = 0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cycles = 0; mismatches = 0; checked = 0; sent = 0; poses = 0;
    burst_left = 0; hold_left = 0; no_gaps = 0;
    path_len = 0;
    la_dist = 32768; speed = 614; gain = 384; tol_dist = 16384; rate_lim = 4096;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    set_all(32768, 614, 384, 16384, 4096);
    test_backpressure();
    set_all(0, 0, 0, 0, 0);
    test_random(70);
    set_all(32'h7fffffff, 32767, 65535, 32'h7fffffff, 32767);
    test_random(30);
    set_all(131072, 32767, 65535, 300, 32767);
    test_random(80);
    set_all($urandom_range(0, 400000), $urandom_range(0, 32767), $urandom_range(0, 65535),
            $urandom_range(0, 20000), $urandom_range(0, 32767));
    test_random(80);
    set_all(20000, 8000, 1024, 0, 2000);
    test_random(80);
    set_all(65536, 614, 384, 16384, 4096);
    test_random(60);
    $display("covered %0d requests (%0d pose queries), %0d responses checked, %0d mismatches",
             sent, poses, checked, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
